// ----- hw/rtl/pwc_pkg.sv -----
// shared types, constants and curve weights for the polygon winding coverage block
`timescale 1ns / 1ps

package pwc_pkg;

  localparam int COORD_W        = 24;
  localparam int MUL_W          = 26;
  localparam int ACC_W          = 40;
  localparam int WIND_W         = 14;
  localparam int WIND_LIMIT     = 256;
  localparam int OUT_WIND_W     = 10;
  localparam int PIX_W          = 12;
  localparam int CLIP_W         = 13;
  localparam int CURVE_SEGMENTS = 16;
  localparam int SEG_W          = 5;
  localparam int WEIGHT_W       = 13;
  localparam int CURVE_SHIFT    = 12;
  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_FRAC_BITS    = 8;
  localparam int DEF_IMAGE_SIZE   = 4096;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [2*MUL_W-1:0] mul_prod_t;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_CURVE = 2'd2,
    ACT_PIXEL = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    TERM_START = 2'd0,
    TERM_CTRL1 = 2'd1,
    TERM_CTRL2 = 2'd2,
    TERM_END   = 2'd3
  } term_t;

  typedef enum logic [1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_TOP    = 2'd1,
    CFG_CLIP_WIDTH  = 2'd2,
    CFG_CLIP_HEIGHT = 2'd3
  } cfg_reg_t;

  // bernstein weight for term at step seg out of CURVE_SEGMENTS, scaled by segments cubed
  function automatic logic [WEIGHT_W-1:0] bern_weight(input term_t term,
                                                      input logic [SEG_W-1:0] seg);
    int m;
    int i;
    int r;
    i = int'(seg);
    m = CURVE_SEGMENTS - i;
    case (term)
      TERM_START: r = m * m * m;
      TERM_CTRL1: r = 3 * m * m * i;
      TERM_CTRL2: r = 3 * m * i * i;
      TERM_END:   r = i * i * i;
      default:    r = 0;
    endcase
    return WEIGHT_W'(r);
  endfunction

endpackage

// ----- hw/rtl/pwc_mul.sv -----
// shared registered signed multiplier for curve weights and edge cross products
`timescale 1ns / 1ps

module pwc_mul
  import pwc_pkg::*;
#(
  parameter int WIDTH = MUL_W
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [WIDTH-1:0]   op_a,
  input  logic signed [WIDTH-1:0]   op_b,
  output logic signed [2*WIDTH-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a * op_b;
    end
  end

endmodule

// ----- hw/rtl/polygon_winding_coverage_core.sv -----
// top level of the polygon winding coverage block: vertex table, curve flattener, pixel test
`timescale 1ns / 1ps

// Keeps a table of up to MAX_VERTICES polygon vertices (signed Q15.8) built from a
// stream of items: clear, add vertex, cubic curve and pixel test. Only a pixel test
// gives a result: the nonzero winding number at the pixel centre, saturated to
// -256..256, a covered flag (inside the clip rectangle, three or more vertices,
// nonzero winding) and the echoed column and row. One item is worked on at a time;
// in_ready is high only while the sequencer is idle. Clear and add are done in the
// idle state. A curve makes 16 new vertices: each needs two coordinates, each a
// four-term weighted sum through the single shared multiplier, with a multiply
// state and an add state per term and then a rounding state. A pixel test walks
// every stored edge with the same multiplier, each edge taking a difference, two
// products and a compare; with fewer than three vertices it goes straight to the
// finishing state. The result sits in an output register, so a new item may be
// taken while it waits. The vertex memory needs no clearing pass after reset:
// only entries below the count are used.
module polygon_winding_coverage_core
  import pwc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int FRAC_BITS    = DEF_FRAC_BITS,
  parameter int IMAGE_SIZE   = DEF_IMAGE_SIZE
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration writes
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [CLIP_W-1:0]            cfg_data,
  // item input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   action,
  input  logic signed [COORD_W-1:0]    point_x,
  input  logic signed [COORD_W-1:0]    point_y,
  input  logic signed [COORD_W-1:0]    ctrl_one_x,
  input  logic signed [COORD_W-1:0]    ctrl_one_y,
  input  logic signed [COORD_W-1:0]    ctrl_two_x,
  input  logic signed [COORD_W-1:0]    ctrl_two_y,
  input  logic [PIX_W-1:0]             pixel_col,
  input  logic [PIX_W-1:0]             pixel_row,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         covered,
  output logic signed [OUT_WIND_W-1:0] winding,
  output logic [PIX_W-1:0]             result_col,
  output logic [PIX_W-1:0]             result_row
);

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int IMGW = $clog2(IMAGE_SIZE + 1);
  localparam int LIMW = (IMGW > CLIP_W + 1) ? IMGW : CLIP_W + 1;
  localparam logic signed [ACC_W-1:0] RoundHalf = ACC_W'(1) <<< (CURVE_SHIFT - 1);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_CRV_RD    = 13'b0000000000010,
    S_CRV_LD    = 13'b0000000000100,
    S_CRV_MUL   = 13'b0000000001000,
    S_CRV_ADD   = 13'b0000000010000,
    S_CRV_RND   = 13'b0000000100000,
    S_WND_RD    = 13'b0000001000000,
    S_WND_FIRST = 13'b0000010000000,
    S_WND_DIFF  = 13'b0000100000000,
    S_WND_M1    = 13'b0001000000000,
    S_WND_M2    = 13'b0010000000000,
    S_WND_CMP   = 13'b0100000000000,
    S_FIN       = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration
  logic [PIX_W-1:0]  clip_left;
  logic [PIX_W-1:0]  clip_top;
  logic [CLIP_W-1:0] clip_width;
  logic [CLIP_W-1:0] clip_height;

  // latched item
  coord_t            end_x, end_y, c1_x, c1_y, c2_x, c2_y;
  logic [PIX_W-1:0]  col, row;

  // vertex table
  logic [2*COORD_W-1:0] mem [MAX_VERTICES];
  logic [2*COORD_W-1:0] rd_data;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [2*COORD_W-1:0] wr_data;
  logic [CW-1:0]        total;
  logic                 full;

  // curve sequencing
  coord_t               start_x, start_y, res_x;
  logic [SEG_W-1:0]     seg;
  term_t                term;
  logic                 coord_y;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  coord_t               rnd_val;
  coord_t               term_pt;

  // edge walk
  coord_t               first_x, first_y, prev_x, prev_y, cur_x, cur_y;
  coord_t               edge_x, edge_y;
  logic [CW-1:0]        idx;
  mul_op_t              dx, dy, qx, qy, samp_x, samp_y;
  mul_prod_t            p1, prod;
  logic signed [2*MUL_W:0] cross_prod;
  logic signed [WIND_W-1:0] wind;

  // shared multiplier
  logic                 mul_en;
  mul_op_t              op_a, op_b;

  logic                 in_fire;
  logic                 in_clip;
  logic signed [OUT_WIND_W-1:0] wind_sat;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (total == CW'(MAX_VERTICES));

  // sample centre: pixel index plus one half in the coordinate format
  assign samp_x = MUL_W'({1'b0, col, 1'b1, {(FRAC_BITS-1){1'b0}}});
  assign samp_y = MUL_W'({1'b0, row, 1'b1, {(FRAC_BITS-1){1'b0}}});

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= '0;
      clip_top    <= '0;
      clip_width  <= CLIP_W'(DEF_IMAGE_SIZE);
      clip_height <= CLIP_W'(DEF_IMAGE_SIZE);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CLIP_LEFT:   clip_left   <= cfg_data[PIX_W-1:0];
        CFG_CLIP_TOP:    clip_top    <= cfg_data[PIX_W-1:0];
        CFG_CLIP_WIDTH:  clip_width  <= cfg_data;
        CFG_CLIP_HEIGHT: clip_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // curve term operand select
  always_comb begin
    case (term)
      TERM_START: term_pt = coord_y ? start_y : start_x;
      TERM_CTRL1: term_pt = coord_y ? c1_y : c1_x;
      TERM_CTRL2: term_pt = coord_y ? c2_y : c2_x;
      TERM_END:   term_pt = coord_y ? end_y : end_x;
      default:    term_pt = '0;
    endcase
  end

  assign rnd     = acc + RoundHalf;
  assign rnd_val = rnd[CURVE_SHIFT +: COORD_W];

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = total[AW-1:0];
    wr_data = {rnd_val, rnd_val};
    case (state)
      S_IDLE: begin
        if (in_fire && action_t'(action) == ACT_ADD && !full) begin
          wr_en   = 1'b1;
          wr_data = {point_x, point_y};
        end
      end
      S_CRV_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(total - CW'(1));
      end
      S_CRV_RND: begin
        if (coord_y && !full) begin
          wr_en   = 1'b1;
          wr_data = {res_x, rnd_val};
        end
      end
      S_WND_RD: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_WND_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(1);
      end
      S_WND_CMP: begin
        rd_en   = 1'b1;
        rd_addr = AW'(idx + CW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // closing edge wraps back to the first vertex
  assign edge_x = (idx == total) ? first_x : rd_data[2*COORD_W-1:COORD_W];
  assign edge_y = (idx == total) ? first_y : rd_data[COORD_W-1:0];

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    op_a   = '0;
    op_b   = '0;
    case (state)
      S_CRV_MUL: begin
        mul_en = 1'b1;
        op_a   = MUL_W'(term_pt);
        op_b   = MUL_W'($signed({1'b0, bern_weight(term, seg)}));
      end
      S_WND_M1: begin
        mul_en = 1'b1;
        op_a   = dx;
        op_b   = qy;
      end
      S_WND_M2: begin
        mul_en = 1'b1;
        op_a   = qx;
        op_b   = dy;
      end
      default: ;
    endcase
  end

  pwc_mul #(
    .WIDTH (MUL_W)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign cross_prod = (2*MUL_W+1)'(p1) - (2*MUL_W+1)'(prod);

  // clip test
  always_comb begin
    logic [LIMW-1:0] col_w, row_w;
    col_w   = LIMW'(col);
    row_w   = LIMW'(row);
    in_clip = (col >= clip_left) && (col_w < LIMW'(clip_left) + LIMW'(clip_width)) &&
              (col_w < LIMW'(IMAGE_SIZE)) &&
              (row >= clip_top) && (row_w < LIMW'(clip_top) + LIMW'(clip_height)) &&
              (row_w < LIMW'(IMAGE_SIZE));
  end

  // saturate the running count to the reported range
  always_comb begin
    if (wind > WIND_W'(WIND_LIMIT)) begin
      wind_sat = OUT_WIND_W'(WIND_LIMIT);
    end else if (wind < -WIND_W'(WIND_LIMIT)) begin
      wind_sat = -OUT_WIND_W'(WIND_LIMIT);
    end else begin
      wind_sat = OUT_WIND_W'(wind);
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // the finishing state reloads the output register itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            end_x <= point_x;
            end_y <= point_y;
            c1_x  <= ctrl_one_x;
            c1_y  <= ctrl_one_y;
            c2_x  <= ctrl_two_x;
            c2_y  <= ctrl_two_y;
            col   <= pixel_col;
            row   <= pixel_row;
            wind  <= '0;
            case (action_t'(action))
              ACT_CLEAR: total <= '0;
              ACT_ADD: begin
                if (!full) begin
                  total <= total + CW'(1);
                end
              end
              ACT_CURVE: begin
                if (total != '0) begin
                  state <= S_CRV_RD;
                end
              end
              ACT_PIXEL: begin
                state <= (total >= CW'(3)) ? S_WND_RD : S_FIN;
              end
              default: ;
            endcase
          end
        end
        S_CRV_RD: state <= S_CRV_LD;
        S_CRV_LD: begin
          start_x <= rd_data[2*COORD_W-1:COORD_W];
          start_y <= rd_data[COORD_W-1:0];
          seg     <= SEG_W'(1);
          term    <= TERM_START;
          coord_y <= 1'b0;
          acc     <= '0;
          state   <= S_CRV_MUL;
        end
        S_CRV_MUL: state <= S_CRV_ADD;
        S_CRV_ADD: begin
          acc   <= acc + ACC_W'(prod);
          term  <= term_t'(term + 2'd1);
          state <= (term == TERM_END) ? S_CRV_RND : S_CRV_MUL;
        end
        S_CRV_RND: begin
          acc  <= '0;
          term <= TERM_START;
          if (!coord_y) begin
            res_x   <= rnd_val;
            coord_y <= 1'b1;
            state   <= S_CRV_MUL;
          end else begin
            coord_y <= 1'b0;
            if (!full) begin
              total <= total + CW'(1);
            end
            if (seg == SEG_W'(CURVE_SEGMENTS)) begin
              state <= S_IDLE;
            end else begin
              seg   <= seg + SEG_W'(1);
              state <= S_CRV_MUL;
            end
          end
        end
        S_WND_RD: state <= S_WND_FIRST;
        S_WND_FIRST: begin
          first_x <= rd_data[2*COORD_W-1:COORD_W];
          first_y <= rd_data[COORD_W-1:0];
          prev_x  <= rd_data[2*COORD_W-1:COORD_W];
          prev_y  <= rd_data[COORD_W-1:0];
          idx     <= CW'(1);
          state   <= S_WND_DIFF;
        end
        S_WND_DIFF: begin
          cur_x <= edge_x;
          cur_y <= edge_y;
          dx    <= MUL_W'(edge_x) - MUL_W'(prev_x);
          dy    <= MUL_W'(edge_y) - MUL_W'(prev_y);
          qx    <= samp_x - MUL_W'(prev_x);
          qy    <= samp_y - MUL_W'(prev_y);
          state <= S_WND_M1;
        end
        S_WND_M1: state <= S_WND_M2;
        S_WND_M2: begin
          p1    <= prod;
          state <= S_WND_CMP;
        end
        S_WND_CMP: begin
          // upward edge counts on or left, downward edge only strictly right
          if (MUL_W'(prev_y) <= samp_y) begin
            if (MUL_W'(cur_y) > samp_y && cross_prod >= 0) begin
              wind <= wind + WIND_W'(1);
            end
          end else if (MUL_W'(cur_y) <= samp_y) begin
            if (cross_prod < 0) begin
              wind <= wind - WIND_W'(1);
            end
          end
          prev_x <= cur_x;
          prev_y <= cur_y;
          if (idx == total) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_WND_DIFF;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            covered    <= in_clip && (total >= CW'(3)) && (wind != '0);
            winding    <= wind_sat;
            result_col <= col;
            result_row <= row;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the vertex count never passes the table size
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(MAX_VERTICES))
    else $error("vertex count above table size");

  // reported winding stays inside the saturation range
  a_wind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (winding <= OUT_WIND_W'(WIND_LIMIT)) && (winding >= -OUT_WIND_W'(WIND_LIMIT)))
    else $error("winding out of range");

  // a covered pixel always has a nonzero winding
  a_cov_wind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && covered) |-> (winding != '0))
    else $error("covered with zero winding");
`endif

endmodule
